/* hw/rtl/tlm_pkg.sv */
`default_nettype none
package tlm_pkg;

   // field widths
   localparam int TIME_W  = 32;
   localparam int ADC_W   = 12;
   localparam int PCT_W   = 16;
   localparam int LIT_W   = 24;
   localparam int CAP_W   = 16;
   localparam int MASK_W  = 4;

   // stream and register port widths
   localparam int REQ_W   = 48;
   localparam int RSP_W   = 112;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 24;

   // parameter defaults
   localparam logic [TIME_W-1:0] READ_INTERVAL_DEF = 32'd1000;
   localparam logic [CAP_W-1:0]  CAPACITY_DEF      = 16'd1000;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_ADC_MIN       = 3'd0;
   localparam logic [CSR_AW-1:0] REG_ADC_MAX       = 3'd1;
   localparam logic [CSR_AW-1:0] REG_OVF_PCT       = 3'd2;
   localparam logic [CSR_AW-1:0] REG_OVF_CLR_PCT   = 3'd3;
   localparam logic [CSR_AW-1:0] REG_CRIT_PCT      = 3'd4;
   localparam logic [CSR_AW-1:0] REG_LOCK_REL_PCT  = 3'd5;
   localparam logic [CSR_AW-1:0] REG_CRIT_SET_LIT  = 3'd6;
   localparam logic [CSR_AW-1:0] REG_CRIT_REL_LIT  = 3'd7;

   // percent scaling: dividend (raw - adc_min) * 10000 needs 26 bits
   localparam int NUM_W   = 26;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam logic [NUM_W-1:0] PCT_SCALE = 26'd10000;

   // divide by 1000 as shift by 3 then reciprocal of 125
   localparam int PROD_W  = 2 * CAP_W;
   localparam int Y_W     = PROD_W - 3;
   localparam int RCP_W   = 30;
   localparam int RCP_SH  = 36;
   localparam int RP_W    = Y_W + RCP_W;
   localparam int Q0_W    = RP_W - RCP_SH;
   localparam logic [RCP_W-1:0] RCP_125 = 30'd549755813;
   localparam logic [RCP_W-1:0] DIV_125 = 30'd125;

   typedef struct packed {
      logic capture;
      logic check;
      logic div_step;
      logic mul;
      logic rec;
      logic fix;
      logic load_out;
   } tlm_cmd_type;

   typedef struct packed {
      logic elapsed;
      logic out_free;
   } tlm_sts_type;

endpackage
`default_nettype wire

/* hw/rtl/tlm_ctrl.sv */
`default_nettype none
module tlm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  tlm_pkg::tlm_sts_type      sts,
   output tlm_pkg::tlm_cmd_type      cmd
);
   import tlm_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_REC   = 3'd4;
   localparam logic [2:0] ST_FIX   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            // a tick inside the read interval is dropped here
            state_in  = sts.elapsed ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_REC;
         end
         ST_REC: begin
            cmd.rec  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/tlm_dp.sv */
`default_nettype none
module tlm_dp #(
   parameter logic [tlm_pkg::TIME_W-1:0] READ_INTERVAL_MS = tlm_pkg::READ_INTERVAL_DEF,
   parameter logic [tlm_pkg::CAP_W-1:0]  CAPACITY_LITERS  = tlm_pkg::CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [tlm_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [tlm_pkg::CSR_DW-1:0]  csr_wdata,
   input  wire logic [tlm_pkg::REQ_W-1:0]   req_tdata,
   output logic [tlm_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  tlm_pkg::tlm_cmd_type             cmd,
   output tlm_pkg::tlm_sts_type             sts
);
   import tlm_pkg::*;

   // configuration
   logic [ADC_W-1:0] adc_min_ff, adc_max_ff;
   logic [PCT_W-1:0] ovf_pct_ff, ovf_clr_ff, crit_pct_ff, lock_rel_ff;
   logic [LIT_W-1:0] crit_set_ff, crit_rel_ff;

   // state
   logic [TIME_W-1:0] last_ff;
   logic              lk_ff, al_ff, ov_ff, sf_ff;

   // work registers
   logic [TIME_W-1:0] now_ff;
   logic [ADC_W-1:0]  raw_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [ADC_W-1:0]  den_ff;
   logic [ADC_W-1:0]  rem_ff;
   logic [PROD_W-1:0] pv_ff, pt_ff;
   logic [Q0_W-1:0]   qv0_ff, qt0_ff;
   logic [LIT_W-1:0]  vol_ff, thr_ff;
   logic [RSP_W-1:0]  rsp_tdata_ff;
   logic              rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_min_ff  <= 12'd0;
         adc_max_ff  <= 12'd4095;
         ovf_pct_ff  <= 16'd9500;
         ovf_clr_ff  <= 16'd9000;
         crit_pct_ff <= 16'd1000;
         lock_rel_ff <= 16'd1500;
         crit_set_ff <= 24'd500;
         crit_rel_ff <= 24'd100;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ADC_MIN:      adc_min_ff  <= csr_wdata[ADC_W-1:0];
            REG_ADC_MAX:      adc_max_ff  <= csr_wdata[ADC_W-1:0];
            REG_OVF_PCT:      ovf_pct_ff  <= csr_wdata[PCT_W-1:0];
            REG_OVF_CLR_PCT:  ovf_clr_ff  <= csr_wdata[PCT_W-1:0];
            REG_CRIT_PCT:     crit_pct_ff <= csr_wdata[PCT_W-1:0];
            REG_LOCK_REL_PCT: lock_rel_ff <= csr_wdata[PCT_W-1:0];
            REG_CRIT_SET_LIT: crit_set_ff <= csr_wdata[LIT_W-1:0];
            REG_CRIT_REL_LIT: crit_rel_ff <= csr_wdata[LIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // interval check and percent dividend
   logic [TIME_W-1:0] dt;
   logic              elapsed;
   logic              scale_ok;
   logic [ADC_W-1:0]  diff;
   logic [NUM_W-1:0]  num_init;

   assign dt       = now_ff - last_ff;
   assign elapsed  = dt >= READ_INTERVAL_MS;
   assign scale_ok = (adc_max_ff > adc_min_ff) && (raw_ff > adc_min_ff);
   assign diff     = raw_ff - adc_min_ff;
   assign num_init = NUM_W'(diff) * PCT_SCALE;

   // restoring divider, one quotient bit a cycle
   logic [ADC_W:0] trial;
   logic           qbit;
   logic [ADC_W:0] trial_sub;

   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign qbit      = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   logic [PCT_W-1:0] level;
   assign level = (|num_ff[NUM_W-1:PCT_W]) ? {PCT_W{1'b1}} : num_ff[PCT_W-1:0];

   // reciprocal stage for the divide by 1000
   logic [Y_W-1:0]  yv, yt;
   logic [RP_W-1:0] rpv, rpt;

   assign yv  = pv_ff[PROD_W-1:3];
   assign yt  = pt_ff[PROD_W-1:3];
   assign rpv = RP_W'(yv) * RP_W'(RCP_125);
   assign rpt = RP_W'(yt) * RP_W'(RCP_125);

   // correction: the estimate is low by at most one
   logic [RCP_W-1:0] rv, rt;
   logic [LIT_W-1:0] vol_in, thr_in;

   assign rv     = RCP_W'(yv) - RCP_W'(qv0_ff) * DIV_125;
   assign rt     = RCP_W'(yt) - RCP_W'(qt0_ff) * DIV_125;
   assign vol_in = LIT_W'(qv0_ff) + LIT_W'(rv >= DIV_125);
   assign thr_in = LIT_W'(qt0_ff) + LIT_W'(rt >= DIV_125);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff <= req_tdata[TIME_W-1:0];
         raw_ff <= req_tdata[TIME_W+ADC_W-1:TIME_W];
      end
      if (cmd.check) begin
         num_ff <= scale_ok ? num_init : '0;
         den_ff <= scale_ok ? (adc_max_ff - adc_min_ff) : ADC_W'(1);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? trial_sub[ADC_W-1:0] : trial[ADC_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], qbit};
      end
      if (cmd.mul) begin
         pv_ff <= PROD_W'(level) * PROD_W'(CAPACITY_LITERS);
         pt_ff <= PROD_W'(ovf_pct_ff) * PROD_W'(CAPACITY_LITERS);
      end
      if (cmd.rec) begin
         qv0_ff <= rpv[RP_W-1:RCP_SH];
         qt0_ff <= rpt[RP_W-1:RCP_SH];
      end
      if (cmd.fix) begin
         vol_ff <= vol_in;
         thr_ff <= thr_in;
      end
   end

   // hysteresis and result
   logic [LIT_W-1:0]  excess, room;
   logic              lk, al, ov, sf;
   logic [MASK_W-1:0] mask;

   always_comb begin
      excess = (vol_ff > thr_ff) ? (vol_ff - thr_ff) : '0;
      room   = (thr_ff > vol_ff) ? (thr_ff - vol_ff) : '0;

      lk = lk_ff;
      if (!lk_ff && level < crit_pct_ff) begin
         lk = 1'b1;
      end else if (lk_ff && level >= lock_rel_ff) begin
         lk = 1'b0;
      end

      al = al_ff;
      if (!al_ff && excess >= crit_set_ff) begin
         al = 1'b1;
      end else if (al_ff && excess <= crit_rel_ff) begin
         al = 1'b0;
      end

      ov = ov_ff;
      if (!ov_ff && level > ovf_pct_ff) begin
         ov = 1'b1;
      end else if (ov_ff && level <= ovf_clr_ff) begin
         ov = 1'b0;
      end

      sf   = lk | al;
      mask = {sf ^ sf_ff, ov ^ ov_ff, al ^ al_ff, lk ^ lk_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tdata_ff <= {4'b0, mask, sf, ov, al, lk, room, excess, vol_ff, level, raw_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff       <= '0;
         lk_ff         <= 1'b0;
         al_ff         <= 1'b0;
         ov_ff         <= 1'b0;
         sf_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.check && elapsed) begin
            last_ff <= now_ff;
         end
         if (cmd.load_out) begin
            lk_ff <= lk;
            al_ff <= al;
            ov_ff <= ov;
            sf_ff <= sf;
         end
         if (cmd.load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tvalid   = rsp_tvalid_ff;
   assign sts.elapsed  = elapsed;
   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

endmodule
`default_nettype wire

/* hw/rtl/tank_level_monitor_hysteresis.sv */
`default_nettype none
// channel   | direction | ports                         | payload
// ----------+-----------+-------------------------------+---------------------------------
// req       | in        | req_tvalid req_tready         | req_tdata: now_ms, raw_level
// rsp       | out       | rsp_tvalid rsp_tready         | rsp_tdata: level result
// csr       | in        | csr_we csr_addr csr_wdata     | register write, no read-back
//
// a tick that reads passes the check state, the divide steps of the restoring divider
// for the percent scale, the multiply, reciprocal and fix states and the load step;
// the next tick can transfer in the cycle after the load
// a tick inside the read interval is dropped at the next edge, and the next tick can
// transfer once the controller is back in idle
// one tick at a time: req_tready is high only while the controller is idle
// a held result stalls the next read only at its final load step
// reset is synchronous, active high, and restores register defaults and flags
module tank_level_monitor_hysteresis #(
   parameter logic [tlm_pkg::TIME_W-1:0] READ_INTERVAL_MS = tlm_pkg::READ_INTERVAL_DEF,
   parameter logic [tlm_pkg::CAP_W-1:0]  CAPACITY_LITERS  = tlm_pkg::CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // [31:0] now_ms, [43:32] raw_level
   input  wire logic [tlm_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // [11:0] raw_echo, [27:12] level_percent, [51:28] volume_liters,
   // [75:52] excess_liters, [99:76] room_liters, [100] low_lockout,
   // [101] crit_alarm, [102] overflow_flag, [103] zone_inhibit, [107:104] changed_mask
   output logic [tlm_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic [tlm_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [tlm_pkg::CSR_DW-1:0]  csr_wdata
);
   import tlm_pkg::*;

   tlm_cmd_type cmd;
   tlm_sts_type sts;

   tlm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tlm_dp #(
      .READ_INTERVAL_MS (READ_INTERVAL_MS),
      .CAPACITY_LITERS  (CAPACITY_LITERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // a waiting result is never overwritten
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over a pending transfer");

   // one tick in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second tick accepted while busy");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.check, cmd.div_step, cmd.mul, cmd.rec, cmd.fix,
                cmd.load_out}))
      else $error("controller issued overlapping commands");

endmodule
`default_nettype wire

/* tb/level_result_checker.sv */
module level_result_checker #(
   parameter logic [tlm_pkg::TIME_W-1:0] READ_INTERVAL_MS = tlm_pkg::READ_INTERVAL_DEF,
   parameter logic [tlm_pkg::CAP_W-1:0]  CAPACITY_LITERS  = tlm_pkg::CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   // [31:0] now_ms, [43:32] raw_level
   input  wire logic [tlm_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   // [11:0] raw_echo, [27:12] level_percent, [51:28] volume_liters,
   // [75:52] excess_liters, [99:76] room_liters, [100] low_lockout,
   // [101] crit_alarm, [102] overflow_flag, [103] zone_inhibit, [107:104] changed_mask
   input  wire logic [tlm_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic [tlm_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [tlm_pkg::CSR_DW-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               pending
);
   import tlm_pkg::*;

   typedef struct packed {
      logic [ADC_W-1:0]  raw;
      logic [PCT_W-1:0]  level;
      logic [LIT_W-1:0]  volume;
      logic [LIT_W-1:0]  excess;
      logic [LIT_W-1:0]  room;
      logic              lockout;
      logic              alarm;
      logic              overflow;
      logic              safety;
      logic [MASK_W-1:0] changed;
   } level_result_type;

   localparam logic [63:0] PCT_MAX = 64'hFFFF;
   localparam logic [63:0] LIT_MAX = 64'hFF_FFFF;

   // register copies
   logic [ADC_W-1:0]  adc_min, adc_max;
   logic [PCT_W-1:0]  ovf_pct, ovf_clr_pct, crit_pct, lock_rel_pct;
   logic [LIT_W-1:0]  crit_set_lit, crit_rel_lit;

   // tracked state
   logic [TIME_W-1:0] last_read_ms;
   logic              lockout_q, alarm_q, overflow_q, safety_q;

   level_result_type  level_results_due[$];
   int                error_count;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input longint unsigned got,
                                input longint unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic level_result_type unpack_result(input logic [RSP_W-1:0] d);
      level_result_type r;
      r.raw      = d[11:0];
      r.level    = d[27:12];
      r.volume   = d[51:28];
      r.excess   = d[75:52];
      r.room     = d[99:76];
      r.lockout  = d[100];
      r.alarm    = d[101];
      r.overflow = d[102];
      r.safety   = d[103];
      r.changed  = d[107:104];
      return r;
   endfunction

   // returns 1 when the tick reads the sample, with the result it must produce
   function automatic bit sample_level(input logic [TIME_W-1:0] now_ms,
                                       input logic [ADC_W-1:0] raw,
                                       output level_result_type res);
      logic [TIME_W-1:0] elapsed;
      logic [63:0] level, volume, limit_vol, excess, room;
      logic lk, al, ov, sf;
      elapsed = now_ms - last_read_ms;
      res = '0;
      if (elapsed < READ_INTERVAL_MS)
         return 1'b0;
      last_read_ms = now_ms;

      level = '0;
      if (adc_max > adc_min && raw > adc_min) begin
         level = 64'(raw - adc_min) * 64'd10000 / 64'(adc_max - adc_min);
         if (level > PCT_MAX)
            level = PCT_MAX;
      end
      volume = level * 64'(CAPACITY_LITERS) / 64'd1000;
      if (volume > LIT_MAX)
         volume = LIT_MAX;
      limit_vol = 64'(ovf_pct) * 64'(CAPACITY_LITERS) / 64'd1000;
      if (limit_vol > LIT_MAX)
         limit_vol = LIT_MAX;
      excess = volume > limit_vol ? volume - limit_vol : 64'd0;
      room   = limit_vol > volume ? limit_vol - volume : 64'd0;

      lk = lockout_q;
      if (!lk && level < crit_pct)
         lk = 1'b1;
      else if (lk && level >= lock_rel_pct)
         lk = 1'b0;

      al = alarm_q;
      if (!al && excess >= crit_set_lit)
         al = 1'b1;
      else if (al && excess <= crit_rel_lit)
         al = 1'b0;

      ov = overflow_q;
      if (!ov && level > ovf_pct)
         ov = 1'b1;
      else if (ov && level <= ovf_clr_pct)
         ov = 1'b0;

      sf = lk | al;

      res.raw      = raw;
      res.level    = level[PCT_W-1:0];
      res.volume   = volume[LIT_W-1:0];
      res.excess   = excess[LIT_W-1:0];
      res.room     = room[LIT_W-1:0];
      res.lockout  = lk;
      res.alarm    = al;
      res.overflow = ov;
      res.safety   = sf;
      res.changed  = {sf != safety_q, ov != overflow_q, al != alarm_q, lk != lockout_q};

      lockout_q  = lk;
      alarm_q    = al;
      overflow_q = ov;
      safety_q   = sf;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch_channels
      level_result_type got_res, want_res;
      if (reset) begin
         adc_min      = '0;
         adc_max      = 12'd4095;
         ovf_pct      = 16'd9500;
         ovf_clr_pct  = 16'd9000;
         crit_pct     = 16'd1000;
         lock_rel_pct = 16'd1500;
         crit_set_lit = 24'd500;
         crit_rel_lit = 24'd100;
         last_read_ms = '0;
         lockout_q    = 1'b0;
         alarm_q      = 1'b0;
         overflow_q   = 1'b0;
         safety_q     = 1'b0;
         level_results_due.delete();
         error_count  = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_ADC_MIN:      adc_min      = csr_wdata[ADC_W-1:0];
               REG_ADC_MAX:      adc_max      = csr_wdata[ADC_W-1:0];
               REG_OVF_PCT:      ovf_pct      = csr_wdata[PCT_W-1:0];
               REG_OVF_CLR_PCT:  ovf_clr_pct  = csr_wdata[PCT_W-1:0];
               REG_CRIT_PCT:     crit_pct     = csr_wdata[PCT_W-1:0];
               REG_LOCK_REL_PCT: lock_rel_pct = csr_wdata[PCT_W-1:0];
               REG_CRIT_SET_LIT: crit_set_lit = csr_wdata[LIT_W-1:0];
               REG_CRIT_REL_LIT: crit_rel_lit = csr_wdata[LIT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got_res = unpack_result(rsp_tdata);
            if (level_results_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result, raw_echo %0d", got_res.raw));
            end else begin
               want_res = level_results_due.pop_front();
               compare_field("raw_echo",      got_res.raw,      want_res.raw);
               compare_field("level_percent", got_res.level,    want_res.level);
               compare_field("volume_liters", got_res.volume,   want_res.volume);
               compare_field("excess_liters", got_res.excess,   want_res.excess);
               compare_field("room_liters",   got_res.room,     want_res.room);
               compare_field("low_lockout",   got_res.lockout,  want_res.lockout);
               compare_field("crit_alarm",    got_res.alarm,    want_res.alarm);
               compare_field("overflow_flag", got_res.overflow, want_res.overflow);
               compare_field("zone_inhibit",  got_res.safety,   want_res.safety);
               compare_field("changed_mask",  got_res.changed,  want_res.changed);
            end
         end

         if (req_tvalid && req_tready) begin
            if (sample_level(req_tdata[TIME_W-1:0], req_tdata[TIME_W +: ADC_W], want_res))
               level_results_due.push_back(want_res);
         end
      end
      mismatches <= error_count;
      pending    <= level_results_due.size();
   end

endmodule

/* tb/tank_level_monitor_hysteresis_tb.sv */
module tank_level_monitor_hysteresis_tb;
   import tlm_pkg::*;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int READ_TICKS     = 1100;
   localparam int PHASES         = 10;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT_RESULT = 300;
   localparam int IDLE_PCT       = 16;

   typedef struct {
      logic [ADC_W-1:0] adc_min;
      logic [ADC_W-1:0] adc_max;
      logic [PCT_W-1:0] ovf_pct;
      logic [PCT_W-1:0] ovf_clr_pct;
      logic [PCT_W-1:0] crit_pct;
      logic [PCT_W-1:0] lock_rel_pct;
      logic [LIT_W-1:0] crit_set_lit;
      logic [LIT_W-1:0] crit_rel_lit;
   } tank_settings_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we     = 1'b0;
   logic [CSR_AW-1:0]  csr_addr   = '0;
   logic [CSR_DW-1:0]  csr_wdata  = '0;

   int                 mismatches;
   int                 pending;
   bit                 steady = 1'b0;   // no idling on either side
   int                 cycle_count;
   int                 results_seen = 0;
   int                 hold_left = 0;

   logic [TIME_W-1:0]  now_ms = '0;
   logic [TIME_W-1:0]  since_read = '0;
   int                 reads_sent = 0;
   int                 span_lo = 0;
   int                 span_hi = 4095;
   int                 walk_raw = 2048;

   tank_level_monitor_hysteresis u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   level_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // result side: random stalls, plus one long hold once enough results came out
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            results_seen <= results_seen + 1;
         if (rsp_tvalid && rsp_tready && results_seen == HOLD_AT_RESULT - 1) begin
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // advances the clock time by delta and offers one tick
   task automatic offer_tick(input logic [TIME_W-1:0] delta, input logic [ADC_W-1:0] raw);
      now_ms     = now_ms + delta;
      since_read = since_read + delta;
      if (since_read >= READ_INTERVAL_DEF) begin
         since_read = '0;
         reads_sent++;
      end
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - TIME_W - ADC_W){1'b0}}, raw, now_ms};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering until every result is out, then let a dropped tick finish
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // unused upper bits of the narrow registers carry junk
   task automatic apply_settings(input tank_settings_type s);
      write_reg(REG_ADC_MIN,      {12'($urandom), s.adc_min});
      write_reg(REG_ADC_MAX,      {12'($urandom), s.adc_max});
      write_reg(REG_OVF_PCT,      {8'($urandom), s.ovf_pct});
      write_reg(REG_OVF_CLR_PCT,  {8'($urandom), s.ovf_clr_pct});
      write_reg(REG_CRIT_PCT,     {8'($urandom), s.crit_pct});
      write_reg(REG_LOCK_REL_PCT, {8'($urandom), s.lock_rel_pct});
      write_reg(REG_CRIT_SET_LIT, s.crit_set_lit);
      write_reg(REG_CRIT_REL_LIT, s.crit_rel_lit);
      csr_we   <= 1'b0;
      span_lo  = s.adc_min;
      span_hi  = s.adc_max;
      walk_raw = (span_lo + span_hi) / 2;
   endtask

   function automatic tank_settings_type span_settings(input int lo, input int hi);
      tank_settings_type s;
      s.adc_min      = ADC_W'(lo);
      s.adc_max      = ADC_W'(hi);
      s.ovf_pct      = 16'd9500;
      s.ovf_clr_pct  = 16'd9000;
      s.crit_pct     = 16'd1000;
      s.lock_rel_pct = 16'd1500;
      s.crit_set_lit = 24'd500;
      s.crit_rel_lit = 24'd100;
      return s;
   endfunction

   function automatic tank_settings_type pick_settings(input int phase);
      tank_settings_type s;
      int lo;
      case (phase % 5)
         0: begin
            s = span_settings($urandom_range(1500), $urandom_range(4095, 2500));
            s.ovf_pct      = PCT_W'($urandom_range(10000, 7000));
            s.ovf_clr_pct  = s.ovf_pct - PCT_W'($urandom_range(1500));
            s.crit_pct     = PCT_W'($urandom_range(2000, 500));
            s.lock_rel_pct = s.crit_pct + PCT_W'($urandom_range(1000));
            s.crit_set_lit = LIT_W'($urandom_range(1000));
            s.crit_rel_lit = LIT_W'($urandom_range(s.crit_set_lit));
         end
         1: begin
            s = span_settings(0, 0);
            s.ovf_pct      = '0;
            s.ovf_clr_pct  = '0;
            s.crit_pct     = '0;
            s.lock_rel_pct = '0;
            s.crit_set_lit = '0;
            s.crit_rel_lit = '0;
         end
         2: begin
            s = span_settings(0, 4095);
            s.ovf_pct      = '1;
            s.ovf_clr_pct  = '1;
            s.crit_pct     = '1;
            s.lock_rel_pct = '1;
            s.crit_set_lit = '1;
            s.crit_rel_lit = '1;
         end
         3: begin
            // narrow span drives the level into saturation
            lo = $urandom_range(4000);
            s = span_settings(lo, lo + $urandom_range(40, 1));
            s.ovf_pct      = PCT_W'($urandom);
            s.ovf_clr_pct  = PCT_W'($urandom);
            s.crit_pct     = PCT_W'($urandom);
            s.lock_rel_pct = PCT_W'($urandom);
            s.crit_set_lit = LIT_W'($urandom_range(70000));
            s.crit_rel_lit = LIT_W'($urandom_range(70000));
         end
         default: begin
            s = span_settings($urandom_range(4095), $urandom_range(4095));
            s.ovf_pct      = PCT_W'($urandom_range(12000));
            s.ovf_clr_pct  = PCT_W'($urandom_range(12000));
            s.crit_pct     = PCT_W'($urandom_range(12000));
            s.lock_rel_pct = PCT_W'($urandom_range(12000));
            s.crit_set_lit = LIT_W'($urandom);
            s.crit_rel_lit = LIT_W'($urandom_range(3000));
         end
      endcase
      return s;
   endfunction

   // uniform samples, samples near the span ends, and a slow walk for hysteresis
   function automatic logic [ADC_W-1:0] pick_raw();
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 40) begin
         v = $urandom_range(4095);
      end else if (r < 60) begin
         v = ($urandom_range(1) ? span_lo : span_hi) + $urandom_range(16) - 8;
      end else begin
         walk_raw = walk_raw + $urandom_range(200) - 100;
         if (walk_raw < 0)
            walk_raw = 0;
         if (walk_raw > 4095)
            walk_raw = 4095;
         v = walk_raw;
      end
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return ADC_W'(v);
   endfunction

   function automatic logic [TIME_W-1:0] pick_delta();
      int r;
      r = $urandom_range(99);
      if (r < 12)
         return TIME_W'($urandom_range(999));
      else if (r < 17)
         return TIME_W'($urandom);
      else if (r < 25)
         return READ_INTERVAL_DEF;
      else
         return TIME_W'($urandom_range(2500, 1000));
   endfunction

   initial begin
      int phase_end;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings
      offer_tick(32'd999, 12'd0);        // first tick just short of the interval
      offer_tick(32'd1, 12'd0);          // empty tank sets lockout
      offer_tick(32'd500, 12'd4095);     // inside the interval, dropped
      offer_tick(32'd499, 12'd4095);
      offer_tick(32'd1, 12'd4095);       // full tank: overflow and alarm
      offer_tick(32'd1000, 12'hAAA);
      offer_tick(32'd1000, 12'h555);
      offer_tick(32'd1000, 12'd3850);
      offer_tick(32'd1000, 12'd3932);
      offer_tick(32'd1000, 12'd3768);    // overflow held between thresholds
      offer_tick(32'hFFFF_FFFF - now_ms - 32'd200, 12'd400);
      offer_tick(32'd1000, 12'd600);     // time wraps past zero
      offer_tick(32'd1000, 12'd615);
      settle();

      apply_settings(span_settings(3000, 3000));   // empty span
      offer_tick(32'd1000, 12'd4095);
      offer_tick(32'd1000, 12'd0);
      settle();
      apply_settings(span_settings(4000, 100));    // inverted span
      offer_tick(32'd1000, 12'd4095);
      settle();
      apply_settings(span_settings(2000, 2003));   // level saturates
      offer_tick(32'd1000, 12'd1990);
      offer_tick(32'd1000, 12'd2000);
      offer_tick(32'd1000, 12'd4095);
      offer_tick(32'd1000, 12'd2001);
      offer_tick(32'd1000, 12'd2002);
      settle();

      // random phases, each under its own register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         apply_settings(pick_settings(phase));
         steady <= (phase == 6);
         phase_end = reads_sent + READ_TICKS / PHASES;
         while (reads_sent < phase_end)
            offer_tick(pick_delta(), pick_raw());
         settle();
      end

      @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/tlm_pkg.sv
hw/rtl/tlm_ctrl.sv
hw/rtl/tlm_dp.sv
hw/rtl/tank_level_monitor_hysteresis.sv
tb/level_result_checker.sv
tb/tank_level_monitor_hysteresis_tb.sv
